>>> sv/ventilator_phase_valve_controller_macros.svh
// Assertion macros for the controller sequencer (vpvc_ctrl).
// VPVC_ASSERT_IMP: same-cycle implication; VPVC_ASSERT_NXT: next-cycle implication.
`ifndef VENTILATOR_PHASE_VALVE_CONTROLLER_MACROS_SVH
`define VENTILATOR_PHASE_VALVE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define VPVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpvc: same-cycle check failed");
`define VPVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpvc: next-cycle check failed");
`else
`define VPVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VPVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/vpvc_pkg.sv
package vpvc_pkg;

  // Valve geometry and pressure width
  localparam int CLOSED_ANGLE  = 90;
  localparam int ANGLE_SCALE   = 1;
  localparam int MAX_OPENING   = 45;
  localparam int PRESSURE_BITS = 12;
  localparam int OPEN_ANGLE    = CLOSED_ANGLE + ANGLE_SCALE * MAX_OPENING;
  localparam int MAX_ANGLE     = 180;

  // Inhalation length is (6000 / bpm) / 3, which equals 2000 / bpm
  localparam int LEN_NUM = (60 * 100) / 3;
  localparam int LEN_W   = 11;
  localparam int CNT_W   = $clog2(LEN_W);
  localparam int BPM_W   = 6;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 12;

  localparam logic [CFG_AW-1:0] REG_BPM      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_APERTURE = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_PEEP = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_PLAT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_PEAK = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FAILSAFE = 3'd5;

  // Item kind carried in in_tuser
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Breathing phase codes
  localparam logic [1:0] PH_INHALE  = 2'd0;
  localparam logic [1:0] PH_PLATEAU = 2'd1;
  localparam logic [1:0] PH_EXHALE  = 2'd2;
  localparam logic [1:0] PH_HOLD    = 2'd3;

  localparam int IN_DW  = 48;
  localparam int OUT_DW = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } vpvc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic div_start;
    logic load_tick;
    logic load_start;
  } vpvc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_item;
    logic div_done;
  } vpvc_sts_t;

  // Saturate an angle into 0..180
  function automatic logic [7:0] clamp_angle(input logic signed [9:0] a);
    logic [7:0] r;
    if (a < 10'sd0) r = 8'd0;
    else if (a > 10'(MAX_ANGLE)) r = 8'(MAX_ANGLE);
    else r = a[7:0];
    return r;
  endfunction

endpackage

>>> sv/vpvc_div.sv
// Restoring divider: LEN_NUM / divisor, one quotient bit per cycle
module vpvc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [vpvc_pkg::BPM_W-1:0]      divisor,
  output logic                            done,
  output logic [vpvc_pkg::LEN_W-1:0]      quot
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [vpvc_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [vpvc_pkg::LEN_W-1:0]     q_r, q_nxt;
  logic [vpvc_pkg::BPM_W-1:0]     rem_r, rem_nxt;
  logic [vpvc_pkg::BPM_W-1:0]     dvs_r, dvs_nxt;
  logic [vpvc_pkg::BPM_W:0]       trial;
  logic                           qbit;

  // One shift-subtract step
  always_comb begin
    trial    = {rem_r, q_r[vpvc_pkg::LEN_W-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = vpvc_pkg::LEN_W'(vpvc_pkg::LEN_NUM);
      rem_nxt  = '0;
      // a zero rate counts as one
      dvs_nxt  = (divisor == '0) ? vpvc_pkg::BPM_W'(1) : divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[vpvc_pkg::LEN_W-2:0], qbit};
      rem_nxt = qbit ? vpvc_pkg::BPM_W'(trial - {1'b0, dvs_r})
                     : trial[vpvc_pkg::BPM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == vpvc_pkg::CNT_W'(vpvc_pkg::LEN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> sv/vpvc_datapath.sv
// Settings, breath state, tick evaluation and the result register
module vpvc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vpvc_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [vpvc_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic [vpvc_pkg::IN_DW-1:0]        in_tdata,
  input  logic                              in_tuser,
  input  vpvc_pkg::vpvc_cmd_t               cmd,
  output vpvc_pkg::vpvc_sts_t               sts,
  output logic [vpvc_pkg::OUT_DW-1:0]       out_tdata
);

  // Settings
  logic [5:0]  bpm_r;
  logic [5:0]  aper_r;
  logic [11:0] min_peep_r;
  logic [11:0] max_plat_r;
  logic [11:0] max_peak_r;
  logic [7:0]  failsafe_r;

  // Breath state
  logic signed [12:0]          peak_r, peak_nxt;
  logic signed [12:0]          plat_r, plat_nxt;
  logic signed [12:0]          peep_r, peep_nxt;
  logic [vpvc_pkg::LEN_W-1:0]  len_r, len_nxt;

  // Result register
  logic [1:0]  res_phase_r, res_phase_nxt;
  logic [7:0]  res_blow_r, res_blow_nxt;
  logic [7:0]  res_pat_r, res_pat_nxt;

  logic [15:0] csec;
  logic [vpvc_pkg::PRESSURE_BITS-1:0] pres;
  logic [7:0]  bpos;
  logic [7:0]  ppos;
  logic signed [12:0] pres_s;
  logic [1:0]  t_phase;
  logic [1:0]  t_phase_out;
  logic [7:0]  t_blow;
  logic [7:0]  t_pat;
  logic        div_done;
  logic [vpvc_pkg::LEN_W-1:0] div_quot;

  assign csec   = in_tdata[15:0];
  assign pres   = in_tdata[27:16];
  assign bpos   = in_tdata[35:28];
  assign ppos   = in_tdata[43:36];
  assign pres_s = $signed({1'b0, pres});

  vpvc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (bpm_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign sts.start_item = (in_tuser == vpvc_pkg::CMD_START);
  assign sts.div_done   = div_done;

  // Settings write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpm_r      <= 6'd20;
      aper_r     <= 6'd45;
      min_peep_r <= 12'd50;
      max_plat_r <= 12'd400;
      max_peak_r <= 12'd450;
      failsafe_r <= 8'd90;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        vpvc_pkg::REG_BPM:      bpm_r      <= cfg_wdata[5:0];
        vpvc_pkg::REG_APERTURE: aper_r     <= cfg_wdata[5:0];
        vpvc_pkg::REG_MIN_PEEP: min_peep_r <= cfg_wdata;
        vpvc_pkg::REG_MAX_PLAT: max_plat_r <= cfg_wdata;
        vpvc_pkg::REG_MAX_PEAK: max_peak_r <= cfg_wdata;
        vpvc_pkg::REG_FAILSAFE: failsafe_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Evaluate one tick: phase, valve angles, safeguards
  always_comb begin
    if (csec <= {5'b0, len_r}) begin
      t_phase = (pres_s >= peak_r) ? vpvc_pkg::PH_INHALE : vpvc_pkg::PH_PLATEAU;
    end else begin
      t_phase = vpvc_pkg::PH_EXHALE;
    end
    case (t_phase)
      vpvc_pkg::PH_INHALE: begin
        t_blow = vpvc_pkg::clamp_angle($signed(10'(vpvc_pkg::CLOSED_ANGLE))
                 - $signed(10'(vpvc_pkg::ANGLE_SCALE * aper_r)));
        t_pat  = vpvc_pkg::clamp_angle(10'(vpvc_pkg::OPEN_ANGLE));
      end
      vpvc_pkg::PH_PLATEAU: begin
        t_blow = vpvc_pkg::clamp_angle(10'(vpvc_pkg::OPEN_ANGLE));
        t_pat  = vpvc_pkg::clamp_angle(10'(vpvc_pkg::CLOSED_ANGLE));
      end
      default: begin
        t_blow = vpvc_pkg::clamp_angle(10'(vpvc_pkg::OPEN_ANGLE));
        t_pat  = vpvc_pkg::clamp_angle($signed({2'b00, failsafe_r}));
      end
    endcase
    t_phase_out = t_phase;
    // overpeak: step the blower valve closed
    if (pres > max_peak_r) begin
      t_blow = vpvc_pkg::clamp_angle($signed({2'b00, bpos}) - 10'sd2);
    end
    // overplateau: relieve through the patient valve
    if (t_phase == vpvc_pkg::PH_PLATEAU && pres > max_plat_r) begin
      t_pat = vpvc_pkg::clamp_angle($signed({2'b00, ppos}) + 10'sd1);
    end
    // under-PEEP: hold exhalation
    if (pres < min_peep_r) begin
      t_pat       = vpvc_pkg::clamp_angle(10'(vpvc_pkg::CLOSED_ANGLE));
      t_phase_out = vpvc_pkg::PH_HOLD;
    end
  end

  // Update breath state and result
  always_comb begin
    peak_nxt      = peak_r;
    plat_nxt      = plat_r;
    peep_nxt      = peep_r;
    len_nxt       = len_r;
    res_phase_nxt = res_phase_r;
    res_blow_nxt  = res_blow_r;
    res_pat_nxt   = res_pat_r;
    if (cmd.load_tick) begin
      case (t_phase)
        vpvc_pkg::PH_INHALE:  peak_nxt = pres_s;
        vpvc_pkg::PH_PLATEAU: plat_nxt = pres_s;
        default:              peep_nxt = pres_s;
      endcase
      res_phase_nxt = t_phase_out;
      res_blow_nxt  = t_blow;
      res_pat_nxt   = t_pat;
    end else if (cmd.load_start) begin
      peak_nxt      = -13'sd1;
      plat_nxt      = -13'sd1;
      peep_nxt      = -13'sd1;
      len_nxt       = div_quot;
      res_phase_nxt = vpvc_pkg::PH_INHALE;
      res_blow_nxt  = '0;
      res_pat_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= -13'sd1;
      plat_r <= -13'sd1;
      peep_r <= -13'sd1;
      len_r  <= vpvc_pkg::LEN_W'(100);
    end else begin
      peak_r <= peak_nxt;
      plat_r <= plat_nxt;
      peep_r <= peep_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_phase_r <= res_phase_nxt;
    res_blow_r  <= res_blow_nxt;
    res_pat_r   <= res_pat_nxt;
  end

  assign out_tdata = {7'b0, peep_r, plat_r, peak_r, res_pat_r, res_blow_r, res_phase_r};

endmodule

>>> sv/vpvc_ctrl.sv
`include "ventilator_phase_valve_controller_macros.svh"

// Item sequencer: accept, run the divider for a new breath, present the result
module vpvc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  vpvc_pkg::vpvc_sts_t   sts,
  output vpvc_pkg::vpvc_cmd_t   cmd
);

  vpvc_pkg::vpvc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      vpvc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (sts.start_item) begin
            cmd.div_start = 1'b1;
            state_nxt     = vpvc_pkg::ST_DIV;
          end else begin
            cmd.load_tick = 1'b1;
            state_nxt     = vpvc_pkg::ST_OUT;
          end
        end
      end
      vpvc_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.load_start = 1'b1;
          state_nxt      = vpvc_pkg::ST_OUT;
        end
      end
      vpvc_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = vpvc_pkg::ST_IDLE;
      end
      default: state_nxt = vpvc_pkg::ST_IDLE;
    endcase
  end

  `VPVC_ASSERT_NXT(a_start_divides, clk, rst_n, in_tvalid && in_tready && sts.start_item, state_r == vpvc_pkg::ST_DIV)
  `VPVC_ASSERT_NXT(a_tick_presents, clk, rst_n, in_tvalid && in_tready && !sts.start_item, out_tvalid)
  `VPVC_ASSERT_IMP(a_done_in_div, clk, rst_n, sts.div_done, state_r == vpvc_pkg::ST_DIV)
  `VPVC_ASSERT_NXT(a_result_held, clk, rst_n, out_tvalid && !out_tready, out_tvalid && !in_tready)

endmodule

>>> sv/ventilator_phase_valve_controller.sv
// Breathing-cycle phase and valve controller.
// Input channel (in_*): one item per tick or per breath start. in_tuser says
// which: 0 tick with a measurement, 1 start of a new breath. A tick returns the
// phase, both valve target angles and the recorded peak, plateau and PEEP.
// A breath start clears the recorded pressures to -1 and derives the
// inhalation length, 2000 / breaths_per_minute centiseconds.
// Output channel (out_*): exactly one result item per input item, in order.
// A tick's result is valid the cycle after it is accepted. A breath start
// runs the 11-step restoring divider (one quotient bit per cycle); its done
// flag loads the result register, which is then presented on out_tdata.
// One item is in flight at a time: a new item is accepted only after the
// previous result has been taken.
// When the receiver stalls, the result stays on out_tdata and in_tready stays
// low until it is taken. Reset (rst_n low, synchronous) restores the settings
// to their defaults, the recorded pressures to -1 and the inhalation length
// to 100 centiseconds. Settings are written through cfg_we / cfg_addr /
// cfg_wdata, by the user only while idle; the block does not enforce this.
module ventilator_phase_valve_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vpvc_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [vpvc_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // centisec_in_cycle[15:0], pressure[27:16], blower_position[35:28],
  // patient_position[43:36], zero fill above
  input  logic [vpvc_pkg::IN_DW-1:0]        in_tdata,
  // command[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // phase[1:0], blower_command[9:2], patient_command[17:10],
  // peak_pressure[30:18], plateau_pressure[43:31], peep_pressure[56:44]
  output logic [vpvc_pkg::OUT_DW-1:0]       out_tdata
);

  vpvc_pkg::vpvc_cmd_t cmd;
  vpvc_pkg::vpvc_sts_t sts;

  vpvc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  vpvc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

>>> test/tb_top.sv
module tb_top;
  import vpvc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int CS_PER_MINUTE  = 60 * 100;
  localparam int RANDOM_PHASES  = 8;
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  blower;
    logic [7:0]  patient;
    logic [12:0] peak;
    logic [12:0] plateau;
    logic [12:0] peep;
  } breath_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // centisec_in_cycle[15:0], pressure[27:16], blower_position[35:28],
  // patient_position[43:36], zero fill above
  logic [IN_DW-1:0]  in_tdata = '0;
  // command[0]
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // phase[1:0], blower_command[9:2], patient_command[17:10],
  // peak_pressure[30:18], plateau_pressure[43:31], peep_pressure[56:44]
  logic [OUT_DW-1:0] out_tdata;

  // Settings and breath state mirrored on the bench side
  logic [5:0]  set_bpm;
  logic [5:0]  set_aperture;
  logic [11:0] set_min_peep;
  logic [11:0] set_max_plat;
  logic [11:0] set_max_peak;
  logic [7:0]  set_failsafe;
  int          rec_peak;
  int          rec_plat;
  int          rec_peep;
  int          inh_len;

  breath_result_t expected_q[$];
  int             errors = 0;
  int             items_sent = 0;
  bit             steady = 1'b0;
  int unsigned    ready_left = 0;

  ventilator_phase_valve_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] sat_angle(int a);
    if (a < 0) return 8'd0;
    if (a > MAX_ANGLE) return 8'(MAX_ANGLE);
    return 8'(a);
  endfunction

  task automatic reset_breath_model();
    set_bpm      = 6'd20;
    set_aperture = 6'd45;
    set_min_peep = 12'd50;
    set_max_plat = 12'd400;
    set_max_peak = 12'd450;
    set_failsafe = 8'd90;
    rec_peak     = -1;
    rec_plat     = -1;
    rec_peep     = -1;
    inh_len      = 100;
  endtask

  // Advance the breath state by one item and return the result it yields
  function automatic breath_result_t predict_breath(logic cmd, logic [15:0] csec,
                                                   logic [11:0] pres, logic [7:0] bpos,
                                                   logic [7:0] ppos);
    breath_result_t r;
    int p;
    int rate;
    r = '0;
    p = int'(pres);
    if (cmd == CMD_START) begin
      rec_peak = -1;
      rec_plat = -1;
      rec_peep = -1;
      rate = (set_bpm == 6'd0) ? 1 : int'(set_bpm);
      inh_len = (CS_PER_MINUTE / rate) / 3;
      r.phase = PH_INHALE;
    end else begin
      if (int'(csec) <= inh_len) r.phase = (p >= rec_peak) ? PH_INHALE : PH_PLATEAU;
      else r.phase = PH_EXHALE;
      case (r.phase)
        PH_INHALE: begin
          r.blower  = sat_angle(CLOSED_ANGLE - ANGLE_SCALE * int'(set_aperture));
          r.patient = sat_angle(OPEN_ANGLE);
          rec_peak  = p;
        end
        PH_PLATEAU: begin
          r.blower  = sat_angle(OPEN_ANGLE);
          r.patient = sat_angle(CLOSED_ANGLE);
          rec_plat  = p;
        end
        default: begin
          r.blower  = sat_angle(OPEN_ANGLE);
          r.patient = sat_angle(int'(set_failsafe));
          rec_peep  = p;
        end
      endcase
      // Safeguards, applied in order
      if (pres > set_max_peak) r.blower = sat_angle(int'(bpos) - 2);
      if (r.phase == PH_PLATEAU && pres > set_max_plat) r.patient = sat_angle(int'(ppos) + 1);
      if (pres < set_min_peep) begin
        r.patient = sat_angle(CLOSED_ANGLE);
        r.phase   = PH_HOLD;
      end
    end
    r.peak    = rec_peak[12:0];
    r.plateau = rec_plat[12:0];
    r.peep    = rec_peep[12:0];
    return r;
  endfunction

  // Hold the item until taken, then record what it should produce
  task automatic send_item(logic cmd, logic [15:0] csec, logic [11:0] pres,
                           logic [7:0] bpos, logic [7:0] ppos);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, ppos, bpos, pres, csec};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_breath(cmd, csec, pres, bpos, ppos));
    items_sent++;
  endtask

  // Stop sending and let every pending result drain out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_BPM:      set_bpm      = data[5:0];
      REG_APERTURE: set_aperture = data[5:0];
      REG_MIN_PEEP: set_min_peep = data[11:0];
      REG_MAX_PLAT: set_max_plat = data[11:0];
      REG_MAX_PEAK: set_max_peak = data[11:0];
      REG_FAILSAFE: set_failsafe = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [CFG_DW-1:0] bpm, logic [CFG_DW-1:0] aperture,
                                logic [CFG_DW-1:0] min_peep, logic [CFG_DW-1:0] max_plat,
                                logic [CFG_DW-1:0] max_peak, logic [CFG_DW-1:0] failsafe);
    write_reg(REG_BPM, bpm);
    write_reg(REG_APERTURE, aperture);
    write_reg(REG_MIN_PEEP, min_peep);
    write_reg(REG_MAX_PLAT, max_plat);
    write_reg(REG_MAX_PEAK, max_peak);
    write_reg(REG_FAILSAFE, failsafe);
    cfg_we <= 1'b0;
  endtask

  // Defaults out of reset: 100 cs inhalation, PEEP floor 50, peak limit 450
  task automatic test_reset_defaults();
    send_item(CMD_TICK, 16'd0, 12'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 16'd100, 12'd4095, 8'd180, 8'd0);
    send_item(CMD_TICK, 16'd101, 12'd60, 8'd90, 8'd180);
    send_item(CMD_START, 16'hFFFF, 12'hFFF, 8'd180, 8'd180);
    send_item(CMD_TICK, 16'd0, 12'd45, 8'd10, 8'd10);
  endtask

  // Inhalation boundary at a zero, an all-ones, a low (5) and a mid (35) rate
  task automatic test_rate_extremes();
    wait_idle();
    apply_settings(12'h000, 12'hFC0, 12'd0, 12'd0, 12'd0, 12'hF00);
    send_item(CMD_START, 16'd0, 12'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 16'd2000, 12'd100, 8'd1, 8'd0);
    send_item(CMD_TICK, 16'd2001, 12'd100, 8'd2, 8'd0);
    wait_idle();
    apply_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_item(CMD_START, 16'd0, 12'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 16'd31, 12'd4095, 8'd180, 8'd180);
    send_item(CMD_TICK, 16'd32, 12'd4095, 8'd180, 8'd180);
    wait_idle();
    apply_settings(12'd5, 12'd45, 12'd50, 12'd400, 12'd450, 12'd180);
    send_item(CMD_START, 16'd0, 12'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 16'd400, 12'd200, 8'd90, 8'd90);
    send_item(CMD_TICK, 16'd401, 12'd200, 8'd90, 8'd90);
    wait_idle();
    write_reg(REG_BPM, 12'd35);
    cfg_we <= 1'b0;
    send_item(CMD_START, 16'd0, 12'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 16'd57, 12'd300, 8'd90, 8'd90);
    send_item(CMD_TICK, 16'd58, 12'd300, 8'd90, 8'd90);
  endtask

  // Overpeak and overplateau steps saturating at both ends, and a PEEP hold
  task automatic test_safeguards();
    wait_idle();
    apply_settings(12'd20, 12'd45, 12'd20, 12'd200, 12'd100, 12'd90);
    send_item(CMD_START, 16'd0, 12'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 16'd0, 12'd300, 8'd0, 8'd0);
    send_item(CMD_TICK, 16'd10, 12'd250, 8'd1, 8'd180);
    send_item(CMD_TICK, 16'd20, 12'd10, 8'd180, 8'd180);
    send_item(CMD_TICK, 16'd200, 12'd150, 8'd180, 8'd0);
    send_item(CMD_TICK, 16'hFFFF, 12'hFFF, 8'd2, 8'd0);
  endtask

  function automatic int near_limit();
    int base;
    case ($urandom_range(0, 2))
      0: base = int'(set_max_peak);
      1: base = int'(set_max_plat);
      default: base = int'(set_min_peep);
    endcase
    return base + int'($urandom_range(0, 4)) - 2;
  endfunction

  // One breath: start, rising pressure with dips, then falling past inhalation
  task automatic run_breath();
    int t;
    int p;
    int n;
    int step;
    int k;
    send_item(CMD_START, 16'($urandom), 12'($urandom), 8'($urandom_range(0, 180)),
              8'($urandom_range(0, 180)));
    n = $urandom_range(3, 16);
    step = (inh_len * 2) / n + 1;
    t = 0;
    p = $urandom_range(0, 200);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: t = inh_len;
        1: t = inh_len + 1;
        default: t = t + int'($urandom_range(0, step));
      endcase
      if (t <= inh_len) begin
        p = p + int'($urandom_range(0, 400));
        if ($urandom_range(0, 3) == 0) p = p - 500;
      end else begin
        p = p - int'($urandom_range(0, 300));
      end
      if ($urandom_range(0, 4) == 0) p = near_limit();
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      send_item(CMD_TICK, 16'(t), 12'(p), 8'($urandom_range(0, 180)),
                8'($urandom_range(0, 180)));
    end
  endtask

  // Random settings per stretch: all low, all high, then mixed
  task automatic test_random_breaths();
    int ph;
    int goal;
    logic [CFG_DW-1:0] bpm;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      steady = (ph == 3 || ph == 6);
      if (ph == 0) begin
        apply_settings(12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000);
      end else if (ph == 1) begin
        apply_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      end else begin
        if ($urandom_range(0, 3) == 0) bpm = 12'($urandom);
        else bpm = {6'($urandom), 6'($urandom_range(5, 35))};
        apply_settings(bpm, 12'($urandom), 12'($urandom_range(0, 800)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       12'($urandom));
      end
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 8) begin
          run_breath();
        end else begin
          send_item(($urandom_range(0, 7) == 0) ? CMD_START : CMD_TICK, 16'($urandom),
                    12'($urandom), 8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    reset_breath_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_rate_extremes();
    test_safeguards();
    test_random_breaths();
    wait_idle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: ready bursts broken by stalls of random length
  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (out_tready || steady) begin
      if (steady || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        ready_left <= $urandom_range(0, 7);
      end else begin
        out_tready <= 1'b0;
        ready_left <= pick_gap();
      end
    end else begin
      out_tready <= 1'b1;
      ready_left <= $urandom_range(0, 11);
    end
  end

  task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each taken result with the oldest one outstanding
  always @(posedge clk) begin : check_results
    breath_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("phase", 13'(want.phase), 13'(out_tdata[1:0]));
        check_field("blower_command", 13'(want.blower), 13'(out_tdata[9:2]));
        check_field("patient_command", 13'(want.patient), 13'(out_tdata[17:10]));
        check_field("peak_pressure", want.peak, out_tdata[30:18]);
        check_field("plateau_pressure", want.plateau, out_tdata[43:31]);
        check_field("peep_pressure", want.peep, out_tdata[56:44]);
      end
    end
  end

  // End the run if neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/vpvc_pkg.sv
sv/vpvc_div.sv
sv/vpvc_datapath.sv
sv/vpvc_ctrl.sv
sv/ventilator_phase_valve_controller.sv
test/tb_top.sv
